// ===== hw/rtl/jamd_pkg.sv =====
package jamd_pkg;

  localparam int ADC_BITS      = 12;
  localparam int FRACTION_BITS = 8;
  localparam int NUM_CH        = 4;
  localparam int CH_W          = 2;
  localparam int DIR_W         = NUM_CH;
  localparam int HELD_W        = 16;
  localparam int DB_W          = 15;
  localparam int SCALE_W       = 7;
  localparam int CFG_IDX_W     = 3;

  localparam int PROD_W    = ADC_BITS + SCALE_W;
  localparam int NUM_W     = PROD_W + FRACTION_BITS;
  localparam int Q_W       = SCALE_W + FRACTION_BITS;
  localparam int SAT_W     = HELD_W + 1;
  localparam int QX_W      = (Q_W > SAT_W) ? Q_W : SAT_W;
  localparam int DIV_CNT_W = $clog2(Q_W);
  localparam int S_TDATA_W = ((ADC_BITS + 7) / 8) * 8;
  localparam int M_TDATA_W = HELD_W;
  localparam int M_TUSER_W = CH_W + 1;
  localparam int CFG_DATA_W = (ADC_BITS > DB_W) ? ADC_BITS : DB_W;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [ADC_BITS-1:0] ADC_MAX      = '1;
  localparam logic [ADC_BITS-1:0] CENTRE_RESET = ADC_BITS'(1 << (ADC_BITS - 1));
  localparam logic [DB_W-1:0]     DEADBAND_RESET = DB_W'(1 << FRACTION_BITS);

  localparam logic [SCALE_W-1:0] ANGLE_FULL = SCALE_W'(90);
  localparam logic [SCALE_W-1:0] ANGLE_SNAP = SCALE_W'(87);
  localparam logic [SCALE_W-1:0] FAN_FULL   = SCALE_W'(100);
  localparam logic [SCALE_W-1:0] FAN_SNAP   = SCALE_W'(97);

  localparam logic [CH_W-1:0] FAN_CHANNEL = CH_W'(3);

  localparam logic [SAT_W-1:0] MAG_LIMIT = SAT_W'(1 << (HELD_W - 1));
  localparam logic [SAT_W-1:0] POS_LIMIT = SAT_W'((1 << (HELD_W - 1)) - 1);

  localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_BASE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_ROLL  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_PITCH = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_FAN   = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION    = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND     = CFG_IDX_W'(5);

  typedef logic [NUM_CH-1:0][ADC_BITS-1:0] centre_arr_t;

  typedef struct packed {
    logic [CH_W-1:0]     ch;
    logic [ADC_BITS-1:0] mag;
    logic [ADC_BITS-1:0] den;
    logic                neg;
    logic                fan;
  } job_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SCALE,
    BK_CHECK,
    BK_DIV,
    BK_WRITE
  } back_state_t;

endpackage

// ===== hw/rtl/jamd_front.sv =====
module jamd_front (
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [jamd_pkg::S_TDATA_W-1:0]   s_tdata,   // [11:0] adc_sample
  input  logic [jamd_pkg::CH_W-1:0]        s_tuser,   // [1:0] channel
  input  jamd_pkg::centre_arr_t            centre,
  input  logic [jamd_pkg::DIR_W-1:0]       direction,
  input  logic                             queue_full,
  output logic                             push,
  output jamd_pkg::job_t                   push_job
);
  import jamd_pkg::*;

  logic [ADC_BITS-1:0] adc;
  logic [ADC_BITS-1:0] ctr;
  logic                above;

  assign adc      = s_tdata[ADC_BITS-1:0];
  assign ctr      = centre[s_tuser];
  assign above    = adc > ctr;
  assign s_tready = !queue_full;
  assign push     = s_tvalid && !queue_full;

  always_comb begin
    push_job.ch  = s_tuser;
    push_job.fan = (s_tuser == FAN_CHANNEL);
    if (above) begin
      push_job.mag = adc - ctr;
      push_job.den = ADC_MAX - ctr;
    end else begin
      push_job.mag = ctr - adc;
      push_job.den = ctr;
    end
    // branch sign folded with the channel's direction flag
    push_job.neg = !above ^ direction[s_tuser];
  end

endmodule

// ===== hw/rtl/jamd_queue.sv =====
module jamd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  jamd_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output jamd_pkg::job_t pop_job
);
  import jamd_pkg::*;

  job_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full    = (count == QCNT_W'(QUEUE_DEPTH));
  assign valid   = (count != '0);
  assign pop_job = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop) rd_ptr <= rd_ptr + QPTR_W'(1);
      if (push && !pop) count <= count + QCNT_W'(1);
      else if (pop && !push) count <= count - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_job;
  end

endmodule

// ===== hw/rtl/jamd_back.sv =====
module jamd_back (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            job_valid,
  input  jamd_pkg::job_t                  job_in,
  output logic                            pop,
  input  logic [jamd_pkg::DB_W-1:0]       deadband,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [jamd_pkg::CH_W-1:0]       out_ch,
  output logic signed [jamd_pkg::HELD_W-1:0] out_held,
  output logic                            out_upd
);
  import jamd_pkg::*;

  back_state_t            state, state_next;
  job_t                   job;
  logic [PROD_W-1:0]      prod_a;
  logic [PROD_W-1:0]      prod_b;
  logic [ADC_BITS-1:0]    rem;
  logic [Q_W-1:0]         qd;
  logic [DIV_CNT_W-1:0]   cnt;
  logic signed [HELD_W-1:0] held [NUM_CH];

  logic [SCALE_W-1:0]     full_val;
  logic [SCALE_W-1:0]     snap_val;
  logic [NUM_W-1:0]       num;
  logic [ADC_BITS:0]      trial;
  logic                   trial_ge;
  logic [QX_W-1:0]        q_ext;
  logic [SAT_W-1:0]       q_sat;
  logic [SAT_W-1:0]       cur_wide;
  logic [HELD_W-1:0]      cur;
  logic [SAT_W-1:0]       diff;
  logic [SAT_W-1:0]       abs_diff;
  logic                   upd;
  logic                   write_go;

  assign full_val = job.fan ? FAN_FULL : ANGLE_FULL;
  assign snap_val = job.fan ? FAN_SNAP : ANGLE_SNAP;
  assign num      = NUM_W'(prod_a) << FRACTION_BITS;
  assign trial    = {rem, qd[Q_W-1]};
  assign trial_ge = trial >= {1'b0, job.den};

  // clamp, sign, then compare against the held value
  always_comb begin
    q_ext = QX_W'(qd);
    q_sat = (q_ext > QX_W'(MAG_LIMIT)) ? MAG_LIMIT : SAT_W'(q_ext);
    if (job.neg) cur_wide = SAT_W'(0) - q_sat;
    else if (q_sat > POS_LIMIT) cur_wide = POS_LIMIT;
    else cur_wide = q_sat;
    cur      = cur_wide[HELD_W-1:0];
    diff     = {cur[HELD_W-1], cur} - {held[job.ch][HELD_W-1], held[job.ch]};
    abs_diff = diff[SAT_W-1] ? SAT_W'(0) - diff : diff;
    upd      = abs_diff > SAT_W'(deadband);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= BK_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    write_go   = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (job_valid) begin
          pop        = 1'b1;
          state_next = BK_SCALE;
        end
      end
      BK_SCALE: state_next = BK_CHECK;
      BK_CHECK: begin
        if (job.den == '0 || prod_a >= prod_b) state_next = BK_WRITE;
        else state_next = BK_DIV;
      end
      BK_DIV: begin
        if (cnt == '0) state_next = BK_WRITE;
      end
      BK_WRITE: begin
        if (!out_valid || out_ready) begin
          write_go   = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state)
      BK_IDLE: begin
        if (job_valid) job <= job_in;
      end
      BK_SCALE: begin
        prod_a <= PROD_W'(job.mag) * PROD_W'(full_val);
        prod_b <= PROD_W'(job.den) * PROD_W'(snap_val);
      end
      BK_CHECK: begin
        cnt <= DIV_CNT_W'(Q_W - 1);
        if (job.den == '0) begin
          qd <= '0;
        end else if (prod_a >= prod_b) begin
          qd <= Q_W'(full_val) << FRACTION_BITS;
        end else begin
          // top bits of the dividend are already below the divisor
          rem <= num[NUM_W-1:Q_W];
          qd  <= num[Q_W-1:0];
        end
      end
      BK_DIV: begin
        rem <= trial_ge ? ADC_BITS'(trial - {1'b0, job.den}) : trial[ADC_BITS-1:0];
        qd  <= {qd[Q_W-2:0], trial_ge};
        cnt <= cnt - DIV_CNT_W'(1);
      end
      BK_WRITE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      for (int i = 0; i < NUM_CH; i++) held[i] <= '0;
    end else begin
      if (write_go) begin
        out_valid <= 1'b1;
        if (upd) held[job.ch] <= cur;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (write_go) begin
      out_ch   <= job.ch;
      out_held <= upd ? cur : held[job.ch];
      out_upd  <= upd;
    end
  end

endmodule

// ===== hw/rtl/joystick_axis_map_deadband.sv =====
// channel   | direction | handshake          | payload
// s         | in        | s_tvalid/s_tready  | tdata adc_sample, tuser channel
// m         | out       | m_tvalid/m_tready  | tdata held_value, tuser channel_out, updated
// cfg       | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// a request passes the back end's scale, check, divide and write steps; the restoring
// divider yields one quotient bit per cycle, and a snapped or zero result skips it
// the front classifies in the accept cycle and a two-entry queue lets it take
// two more requests while the back end is busy
// reset restores default centres, direction and deadband and clears held values
// a stalled m_tready holds the result register and parks the back end at its write step
module joystick_axis_map_deadband (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [jamd_pkg::S_TDATA_W-1:0]       s_tdata,   // [11:0] adc_sample
  input  logic [jamd_pkg::CH_W-1:0]            s_tuser,   // [1:0] channel
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [jamd_pkg::M_TDATA_W-1:0]       m_tdata,   // [15:0] held_value
  output logic [jamd_pkg::M_TUSER_W-1:0]       m_tuser,   // [1:0] channel_out, [2] updated
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [jamd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [jamd_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import jamd_pkg::*;

  centre_arr_t          centre;
  logic [DIR_W-1:0]     direction;
  logic [DB_W-1:0]      deadband;

  logic                 push;
  job_t                 push_job;
  logic                 queue_full;
  logic                 pop;
  logic                 job_valid;
  job_t                 pop_job;

  logic [CH_W-1:0]      out_ch;
  logic signed [HELD_W-1:0] out_held;
  logic                 out_upd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CH; i++) centre[i] <= CENTRE_RESET;
      direction <= '0;
      deadband  <= DEADBAND_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_CENTRE_BASE, CFG_CENTRE_ROLL, CFG_CENTRE_PITCH, CFG_CENTRE_FAN:
          centre[cfg_index[CH_W-1:0]] <= cfg_data[ADC_BITS-1:0];
        CFG_DIRECTION: direction <= cfg_data[DIR_W-1:0];
        CFG_DEADBAND:  deadband  <= cfg_data[DB_W-1:0];
        default: begin
        end
      endcase
    end
  end

  jamd_front u_front (
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .centre    (centre),
    .direction (direction),
    .queue_full(queue_full),
    .push      (push),
    .push_job  (push_job)
  );

  jamd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_job(push_job),
    .full    (queue_full),
    .pop     (pop),
    .valid   (job_valid),
    .pop_job (pop_job)
  );

  jamd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .job_valid(job_valid),
    .job_in   (pop_job),
    .pop      (pop),
    .deadband (deadband),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_ch   (out_ch),
    .out_held (out_held),
    .out_upd  (out_upd)
  );

  assign m_tdata = M_TDATA_W'(out_held);
  assign m_tuser = {out_upd, out_ch};

endmodule
